// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define PSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/psm_pkg.sv -----
// ----------------------------------------------------------------------------
// psm_pkg
// Types and constants for the pixel stack median pipeline.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int SAMPLE_W         = 8;
  localparam int NUM_SAMPLES      = 9;
  localparam int COUNT_W          = 4;
  localparam int MAX_IMAGES       = 9;
  localparam int MAX_COUNT        = (MAX_IMAGES < NUM_SAMPLES) ? MAX_IMAGES : NUM_SAMPLES;
  localparam int LAYERS_PER_STAGE = 3;
  localparam int SORT_STAGES      = 3;
  localparam int PIPE_LATENCY     = SORT_STAGES + 2;

  localparam logic [COUNT_W-1:0]  COUNT_RESET = COUNT_W'(9);
  localparam logic [SAMPLE_W-1:0] SAMPLE_PAD  = {SAMPLE_W{1'b1}};

  typedef logic [SAMPLE_W-1:0]                  sample_t;
  typedef logic [COUNT_W-1:0]                   count_t;
  typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef struct packed {
    logic        valid;
    count_t      count;
    sample_vec_t samples;
  } psm_stage_t;

endpackage

// ----- design/pixel_stack_median.sv -----
// ----------------------------------------------------------------------------
// pixel_stack_median
// Temporal median over a stack of co-located pixel samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_sample_0..in_sample_8 and pulse start; a transfer takes
//   place on every edge with start high and busy low. busy is never raised,
//   so one item may be sent every cycle.
//   Only the first image_count samples take part; a count of zero acts as
//   one and counts above nine act as nine.
//   Configuration: cfg_data carries image_count, written on an edge with
//   cfg_valid and cfg_ready high. cfg_ready is always high. Write only while
//   no item is in flight.
//   Output: out_median_value is shown for one cycle with out_valid high,
//   once the item has passed one entry register, three sort stages of
//   three compare-exchange layers each, and one output register.
//   Throughput is one item per clock.
//   Reset: synchronous, active low; clears the pipeline valids and sets
//   image_count to nine. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module pixel_stack_median import psm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample_0,
  input  logic [SAMPLE_W-1:0] in_sample_1,
  input  logic [SAMPLE_W-1:0] in_sample_2,
  input  logic [SAMPLE_W-1:0] in_sample_3,
  input  logic [SAMPLE_W-1:0] in_sample_4,
  input  logic [SAMPLE_W-1:0] in_sample_5,
  input  logic [SAMPLE_W-1:0] in_sample_6,
  input  logic [SAMPLE_W-1:0] in_sample_7,
  input  logic [SAMPLE_W-1:0] in_sample_8,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_median_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  count_t      image_count_r;
  count_t      eff_count;
  sample_vec_t in_vec;

  logic        entry_valid_r;
  count_t      entry_count_r;
  sample_vec_t entry_samples_r;
  sample_vec_t entry_samples_nxt;

  psm_stage_t  pipe [SORT_STAGES+1];

  logic        out_valid_r;
  sample_t     out_median_r;
  sample_t     median_nxt;
  logic        sorted_ok;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_count_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      image_count_r <= cfg_data;
    end
  end

  always_comb begin
    if (image_count_r == '0) begin
      eff_count = count_t'(1);
    end else if (image_count_r > count_t'(MAX_COUNT)) begin
      eff_count = count_t'(MAX_COUNT);
    end else begin
      eff_count = image_count_r;
    end
  end

  assign in_vec = {in_sample_8, in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                   in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  // unused images padded with full scale so they sort to the top
  always_comb begin
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      entry_samples_nxt[i] = (count_t'(i) < eff_count) ? in_vec[i] : SAMPLE_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      entry_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    entry_count_r   <= eff_count;
    entry_samples_r <= entry_samples_nxt;
  end

  assign pipe[0] = '{valid: entry_valid_r, count: entry_count_r, samples: entry_samples_r};

  for (genvar g = 0; g < SORT_STAGES; g++) begin : g_sort
    psm_sort_stage #(
      .FIRST_LAYER (g * LAYERS_PER_STAGE)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (pipe[g]),
      .stage_out (pipe[g+1])
    );
  end

  always_comb begin
    count_t                mid;
    sample_t               hi;
    sample_t               lo;
    logic [SAMPLE_W:0]     sum;
    mid = {1'b0, pipe[SORT_STAGES].count[COUNT_W-1:1]};
    hi  = '0;
    lo  = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (count_t'(i) == mid) begin
        hi = pipe[SORT_STAGES].samples[i];
      end
      if (count_t'(i + 1) == mid) begin
        lo = pipe[SORT_STAGES].samples[i];
      end
    end
    sum = {1'b0, hi} + {1'b0, lo};
    if (pipe[SORT_STAGES].count[0]) begin
      median_nxt = hi;
    end else begin
      median_nxt = sum[SAMPLE_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe[SORT_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_median_r <= median_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_median_r;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < NUM_SAMPLES - 1; i++) begin
      if (pipe[SORT_STAGES].samples[i] > pipe[SORT_STAGES].samples[i+1]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `PSM_ASSERT_IMP(a_sorted, pipe[SORT_STAGES].valid, sorted_ok)
  `PSM_ASSERT_IMP(a_count_range, entry_valid_r,
                  (entry_count_r != '0) && (entry_count_r <= count_t'(MAX_COUNT)))
  `PSM_ASSERT_IMP(a_out_origin, out_valid, $past(start && !busy, PIPE_LATENCY))
  `PSM_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, image_count_r == $past(cfg_data))

endmodule

// ----- design/psm_sort_stage.sv -----
// ----------------------------------------------------------------------------
// psm_sort_stage
// Three odd-even transposition layers followed by a pipeline register.
// ----------------------------------------------------------------------------
module psm_sort_stage import psm_pkg::*; #(
  parameter int FIRST_LAYER = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  psm_stage_t stage_in,
  output psm_stage_t stage_out
);

  logic        valid_r;
  count_t      count_r;
  sample_vec_t samples_r;
  sample_vec_t samples_nxt;

  always_comb begin
    sample_t tmp;
    tmp         = '0;
    samples_nxt = stage_in.samples;
    for (int l = 0; l < LAYERS_PER_STAGE; l++) begin
      for (int i = 0; i < NUM_SAMPLES - 1; i++) begin
        if (((i + FIRST_LAYER + l) & 1) == 0) begin
          if (samples_nxt[i] > samples_nxt[i+1]) begin
            tmp              = samples_nxt[i];
            samples_nxt[i]   = samples_nxt[i+1];
            samples_nxt[i+1] = tmp;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    count_r   <= stage_in.count;
    samples_r <= samples_nxt;
  end

  assign stage_out = '{valid: valid_r, count: count_r, samples: samples_r};

endmodule
